// ----- sv/lpbp_pkg.sv -----
// Package for the LRU page buffer pool: opcodes, action codes and the front-to-back command type.
// No dependencies.
`default_nettype none
package lpbp_pkg;
  typedef enum logic [2:0] {
    OP_GET = 3'd0, OP_DIRTY = 3'd1, OP_ALLOC = 3'd2, OP_FREE = 3'd3, OP_FLUSH = 3'd4
  } op_t;
  typedef enum logic [2:0] {
    ACT_DONE = 3'd0, ACT_WB = 3'd1, ACT_LOAD = 3'd2, ACT_INIT = 3'd3, ACT_NOTFOUND = 3'd4
  } act_t;
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] page;
  } cmd_t;
  typedef enum logic [2:0] {
    B_IDLE, B_SCAN, B_EXEC, B_FLUSH, B_DONE
  } bstate_t;
endpackage
`default_nettype wire

// ----- sv/lpbp_front.sv -----
// Front part: takes commands, resolves allocate page numbers, and holds a two-entry queue.
// Depends on lpbp_pkg.
`default_nettype none
module lpbp_front
  import lpbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] page,
  input  wire logic [31:0] base,
  input  wire logic        pop,
  output cmd_t             head,
  output logic             nonempty,
  output logic             full
);
  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic [31:0] alloc_r;
  cmd_t c;
  always_comb begin
    c.op = op;
    c.page = (op == OP_ALLOC) ? base + alloc_r : page;
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, pop};
  end
  assign head = q_r[rd_r];
  assign nonempty = cnt_r != 2'd0;
  assign full = cnt_r == 2'd2;
  always_ff @(posedge clk) begin
    if (acc) q_r[wr_r] <= c;
    if (!rst_n) begin
      cnt_r <= 2'd0; rd_r <= 1'b0; wr_r <= 1'b0; alloc_r <= 32'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      if (acc && op == OP_ALLOC) alloc_r <= alloc_r + 32'd1;
    end
  end
endmodule
`default_nettype wire

// ----- sv/lpbp_back.sv -----
// Back part: scans the slot table slot by slot, then updates state and emits results.
// Depends on lpbp_pkg.
`default_nettype none
module lpbp_back
  import lpbp_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cmd_t             head,
  input  wire logic        nonempty,
  output logic             pop,
  output logic             idle,
  output logic             out_valid,
  output logic [2:0]       out_action,
  output logic [3:0]       out_slot_index,
  output logic [31:0]      out_result_page,
  output logic             out_last
);
  localparam int SW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  logic [SLOTS-1:0] valid_r, dirty_r;
  logic [31:0] tag_r [SLOTS];
  logic [31:0] stamp_r [SLOTS];
  logic [31:0] ctr_r;
  bstate_t st_r, st_nxt;
  cmd_t cmd_r;
  logic [SW-1:0] i_r;
  logic hit_r, emp_r, wbpend_r, loaddone_r;
  logic [SW-1:0] hs_r, es_r, vs_r;
  logic [31:0] vst_r;
  logic scan_end;
  logic exec_more;
  logic [SW-1:0] slot;
  logic ov_r; logic [2:0] oa_r; logic [3:0] os_r; logic [31:0] op_r; logic ol_r;

  assign scan_end = {{(32-SW){1'b0}}, i_r} == 32'(SLOTS - 1);
  assign slot = hit_r ? hs_r : (emp_r ? es_r : vs_r);
  assign pop = st_r == B_IDLE && nonempty;
  assign idle = st_r == B_IDLE && !nonempty;
  assign out_valid = ov_r; assign out_action = oa_r; assign out_slot_index = os_r;
  assign out_result_page = op_r; assign out_last = ol_r;
  assign exec_more = (cmd_r.op inside {OP_GET, OP_FREE, OP_ALLOC}) && !hit_r && !loaddone_r &&
                     ((!emp_r && dirty_r[vs_r] && !wbpend_r) || cmd_r.op == OP_FREE);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:  if (nonempty) st_nxt = (head.op == OP_FLUSH) ? B_FLUSH : B_SCAN;
      B_SCAN:  if (scan_end) st_nxt = B_EXEC;
      B_EXEC:  if (!exec_more) st_nxt = B_IDLE;
      B_FLUSH: if (scan_end) st_nxt = B_DONE;
      B_DONE:  st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ov_r <= 1'b0;
    if (!rst_n) begin
      st_r <= B_IDLE; valid_r <= '0; dirty_r <= '0; ctr_r <= 32'd1;
      for (int k = 0; k < SLOTS; k++) stamp_r[k] <= 32'd0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        B_IDLE: begin
          cmd_r <= head; i_r <= '0; hit_r <= 1'b0; emp_r <= 1'b0;
          vs_r <= '0; vst_r <= 32'hFFFF_FFFF; wbpend_r <= 1'b0; loaddone_r <= 1'b0;
        end
        B_SCAN: begin
          i_r <= i_r + 1'b1;
          if (valid_r[i_r] && tag_r[i_r] == cmd_r.page && !hit_r) begin
            hit_r <= 1'b1; hs_r <= i_r;
          end
          if (!valid_r[i_r] && !emp_r) begin
            emp_r <= 1'b1; es_r <= i_r;
          end
          if (i_r == '0 || stamp_r[i_r] < vst_r) begin
            vst_r <= stamp_r[i_r]; vs_r <= i_r;
          end
          if (scan_end) wbpend_r <= 1'b0;
        end
        B_EXEC: begin
          ov_r <= 1'b1; ol_r <= 1'b1; os_r <= 4'(slot); op_r <= cmd_r.page;
          if (cmd_r.op == OP_DIRTY) begin
            if (hit_r) begin
              dirty_r[hs_r] <= 1'b1; oa_r <= ACT_DONE;
            end else begin
              oa_r <= ACT_NOTFOUND; os_r <= 4'd0;
            end
          end else if (cmd_r.op == OP_GET || cmd_r.op == OP_FREE ||
                       cmd_r.op == OP_ALLOC) begin
            if (!hit_r && !emp_r && dirty_r[vs_r] && !wbpend_r && !loaddone_r) begin
              oa_r <= ACT_WB; op_r <= tag_r[vs_r]; ol_r <= 1'b0;
              dirty_r[vs_r] <= 1'b0; wbpend_r <= 1'b1;
            end else if (!hit_r && cmd_r.op == OP_FREE && !loaddone_r) begin
              oa_r <= ACT_LOAD; ol_r <= 1'b0; loaddone_r <= 1'b1; wbpend_r <= 1'b1;
            end else begin
              wbpend_r <= 1'b0;
              valid_r[slot] <= 1'b1; tag_r[slot] <= cmd_r.page;
              stamp_r[slot] <= (cmd_r.op == OP_ALLOC && hit_r) ? ctr_r + 32'd1 : ctr_r;
              ctr_r <= ctr_r + ((cmd_r.op == OP_ALLOC && hit_r) ? 32'd2 : 32'd1);
              case (cmd_r.op)
                OP_GET: begin
                  oa_r <= hit_r ? ACT_DONE : ACT_LOAD; dirty_r[slot] <= hit_r & dirty_r[slot];
                end
                OP_FREE: begin oa_r <= ACT_INIT; dirty_r[slot] <= 1'b1; end
                default: begin oa_r <= ACT_INIT; dirty_r[slot] <= 1'b1; end
              endcase
            end
          end else begin
            oa_r <= ACT_NOTFOUND; os_r <= 4'd0;
          end
        end
        B_FLUSH: begin
          i_r <= i_r + 1'b1;
          if (valid_r[i_r] && dirty_r[i_r]) begin
            ov_r <= 1'b1; oa_r <= ACT_WB; os_r <= 4'(i_r); op_r <= tag_r[i_r];
            ol_r <= 1'b0; dirty_r[i_r] <= 1'b0;
          end
        end
        B_DONE: begin
          ov_r <= 1'b1; oa_r <= ACT_DONE; os_r <= 4'd0; op_r <= 32'd0; ol_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/lru_page_buffer_pool.sv -----
// Top level of the LRU page buffer pool: configuration register, front queue and back engine.
// Depends on lpbp_pkg, lpbp_front and lpbp_back.
//
// channel  | ports                              | flow
// input    | start, busy, in_opcode, in_page_*  | beat when start && !busy
// result   | out_valid, out_* fields            | one beat per cycle, no stall
// config   | cfg_valid, cfg_ready, cfg_data     | beat when valid && ready
// A command passes through the back engine's scan (one table slot scanned per cycle) and
// execution, with an extra execute step per write-back or intermediate load.
// The front queue holds two commands; busy is high while it is full.
// Reset is synchronous and clears valid and dirty flags, stamps, queue, alloc count and base.
`default_nettype none
module lru_page_buffer_pool
  import lpbp_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [31:0] in_page_number,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_initial_page_count,
  output logic             out_valid,
  output logic [2:0]       out_action,
  output logic [3:0]       out_slot_index,
  output logic [31:0]      out_result_page,
  output logic             out_last
);
  logic [31:0] base_r;
  cmd_t head;
  logic nonempty, full, pop, idle, acc;
  assign busy = full;
  assign acc = start && !busy;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) base_r <= 32'd0;
    else if (cfg_valid) base_r <= cfg_initial_page_count;
  end
  lpbp_front u_front (.clk, .rst_n, .acc, .op(in_opcode), .page(in_page_number),
    .base(base_r), .pop, .head, .nonempty, .full);
  lpbp_back #(.SLOTS(SLOTS)) u_back (.clk, .rst_n, .head, .nonempty, .pop, .idle,
    .out_valid, .out_action, .out_slot_index, .out_result_page, .out_last);
`ifndef SYNTHESIS
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
    else $error("pop from empty queue");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n) idle |=> !out_valid)
    else $error("result while idle");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for lru_page_buffer_pool: drives page requests and base-page writes,
// predicts every result beat with its own slot-table model, and checks the beats.
// Depends on lpbp_pkg and lru_page_buffer_pool.
`timescale 1ns / 1ps
module testbench;
  import lpbp_pkg::*;

  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [31:0] page;
    logic        last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode = '0;
  logic [31:0] in_page_number = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_initial_page_count = '0;
  logic        out_valid;
  logic [2:0]  out_action;
  logic [3:0]  out_slot_index;
  logic [31:0] out_result_page;
  logic        out_last;

  lru_page_buffer_pool #(.SLOTS(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_page_number(in_page_number),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_initial_page_count(cfg_initial_page_count),
    .out_valid(out_valid), .out_action(out_action), .out_slot_index(out_slot_index),
    .out_result_page(out_result_page), .out_last(out_last)
  );

  logic        cache_valid [SLOTS];
  logic [31:0] cache_tag [SLOTS];
  logic        cache_dirty [SLOTS];
  logic [31:0] cache_age [SLOTS];
  logic [31:0] next_age;
  logic [31:0] alloc_total;
  logic [31:0] page_base;

  beat_t pending_beats[$];
  int    mismatches = 0;
  bit    quiet = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic beat_t mk(logic [2:0] a, int s, logic [31:0] p, logic l);
    beat_t b;
    b.action = a;
    b.slot = s[3:0];
    b.page = p;
    b.last = l;
    return b;
  endfunction

  function automatic int lookup(logic [31:0] page);
    for (int i = 0; i < SLOTS; i++) begin
      if (cache_valid[i] && cache_tag[i] == page) return i;
    end
    return -1;
  endfunction

  function automatic void touch(int s);
    cache_age[s] = next_age;
    next_age = next_age + 1;
  endfunction

  function automatic int claim_slot();
    int victim;
    victim = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!cache_valid[i]) return i;
    end
    for (int i = 1; i < SLOTS; i++) begin
      if (cache_age[i] < cache_age[victim]) victim = i;
    end
    if (cache_dirty[victim]) begin
      pending_beats.push_back(mk(ACT_WB, victim, cache_tag[victim], 1'b0));
      cache_dirty[victim] = 1'b0;
    end
    cache_valid[victim] = 1'b0;
    return victim;
  endfunction

  function automatic int fetch_page(logic [31:0] page, logic load_last, output bit hit);
    int s;
    s = lookup(page);
    hit = (s >= 0);
    if (hit) begin
      touch(s);
      return s;
    end
    s = claim_slot();
    pending_beats.push_back(mk(ACT_LOAD, s, page, load_last));
    cache_tag[s] = page;
    cache_valid[s] = 1'b1;
    cache_dirty[s] = 1'b0;
    touch(s);
    return s;
  endfunction

  function automatic void predict_request(logic [2:0] op, logic [31:0] page);
    int s;
    bit hit;
    logic [31:0] id;
    case (op)
      OP_GET: begin
        s = fetch_page(page, 1'b1, hit);
        if (hit) pending_beats.push_back(mk(ACT_DONE, s, page, 1'b1));
      end
      OP_DIRTY: begin
        s = lookup(page);
        if (s < 0) begin
          pending_beats.push_back(mk(ACT_NOTFOUND, 0, page, 1'b1));
        end else begin
          cache_dirty[s] = 1'b1;
          pending_beats.push_back(mk(ACT_DONE, s, page, 1'b1));
        end
      end
      OP_ALLOC: begin
        id = page_base + alloc_total;
        alloc_total = alloc_total + 1;
        s = lookup(id);
        if (s >= 0) touch(s);
        else s = claim_slot();
        cache_tag[s] = id;
        cache_valid[s] = 1'b1;
        cache_dirty[s] = 1'b1;
        touch(s);
        pending_beats.push_back(mk(ACT_INIT, s, id, 1'b1));
      end
      OP_FREE: begin
        s = fetch_page(page, 1'b0, hit);
        cache_dirty[s] = 1'b1;
        pending_beats.push_back(mk(ACT_INIT, s, page, 1'b1));
      end
      OP_FLUSH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (cache_valid[i] && cache_dirty[i]) begin
            pending_beats.push_back(mk(ACT_WB, i, cache_tag[i], 1'b0));
            cache_dirty[i] = 1'b0;
          end
        end
        pending_beats.push_back(mk(ACT_DONE, 0, 32'd0, 1'b1));
      end
      default: pending_beats.push_back(mk(ACT_NOTFOUND, 0, page, 1'b1));
    endcase
  endfunction

  task automatic send_request(logic [2:0] op, logic [31:0] page);
    if (!quiet && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_page_number <= page;
    do @(posedge clk); while (busy);
    predict_request(op, page);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);
  endtask

  task automatic write_page_base(logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_initial_page_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_base = value;
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: action %0d slot %0d page %h last %0d",
               out_action, out_slot_index, out_result_page, out_last);
        mismatches++;
      end else begin
        e = pending_beats.pop_front();
        if (out_action !== e.action) begin
          $error("action: expected %0d, actual %0d", e.action, out_action);
          mismatches++;
        end
        if (out_slot_index !== e.slot) begin
          $error("slot_index: expected %0d, actual %0d", e.slot, out_slot_index);
          mismatches++;
        end
        if (out_result_page !== e.page) begin
          $error("result_page: expected %h, actual %h", e.page, out_result_page);
          mismatches++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_last);
          mismatches++;
        end
      end
    end
  end

  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed_requests();
    write_page_base(32'hFFFF_FFFE);
    send_request(OP_GET, 32'h0000_0000);
    send_request(OP_GET, 32'hFFFF_FFFF);
    send_request(OP_DIRTY, 32'hFFFF_FFFF);
    send_request(OP_DIRTY, 32'h0000_0005);
    send_request(OP_GET, 32'h0000_0000);
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_ALLOC, 32'h0);
    send_request(OP_FREE, 32'h0000_0007);
    send_request(OP_FREE, 32'h0000_0000);
    send_request(OP_FLUSH, 32'h0);
    send_request(OP_FLUSH, 32'h0);
    send_request(3'd5, 32'hA5A5_5A5A);
    send_request(3'd6, 32'h5A5A_A5A5);
    send_request(3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(logic [31:0] base, int count);
    logic [2:0]  op;
    logic [31:0] page;
    int          pick;
    write_page_base(base);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 38) op = OP_GET;
      else if (pick < 55) op = OP_DIRTY;
      else if (pick < 70) op = OP_ALLOC;
      else if (pick < 84) op = OP_FREE;
      else if (pick < 93) op = OP_FLUSH;
      else op = 3'($urandom_range(5, 7));
      pick = $urandom_range(99);
      if (pick < 70) page = $urandom_range(0, 23);
      else if (pick < 88) page = base + alloc_total - $urandom_range(0, 6);
      else page = $urandom;
      send_request(op, page);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cache_valid[i] = 1'b0;
      cache_tag[i] = '0;
      cache_dirty[i] = 1'b0;
      cache_age[i] = '0;
    end
    next_age = 32'd1;
    alloc_total = '0;
    page_base = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_requests();
    test_random_traffic(32'h0000_0000, 70);
    quiet = 1'b1;
    test_random_traffic($urandom, 70);
    quiet = 1'b0;
    test_random_traffic(32'hFFFF_FFFF, 70);
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/lpbp_pkg.sv
sv/lpbp_front.sv
sv/lpbp_back.sv
sv/lru_page_buffer_pool.sv
tb/sv/testbench.sv
